@@ src/quaternion_yaw_hold_core_macros.svh @@
// Assertion helpers for the yaw hold block.
`ifndef QUATERNION_YAW_HOLD_CORE_MACROS_SVH
`define QUATERNION_YAW_HOLD_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define QYH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("yaw hold check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define QYH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("yaw hold check failed");

`endif

@@ src/qyh_pkg.sv @@
package qyh_pkg;

    localparam int unsigned QUAT_W    = 16;
    localparam int unsigned PROD_W    = 32;
    localparam int unsigned XY_W      = 36;  // covers CORDIC gain on 2^33 vectors
    localparam int unsigned Z_W       = 28;  // Q24 angle, |z| < 2^27
    localparam int unsigned YAW_W     = 16;
    localparam int unsigned HEAD_W    = 17;
    localparam int unsigned MAX_STEPS = 24;
    localparam int unsigned CORDIC_STEPS_DEFAULT = 16;

    localparam logic signed [XY_W-1:0] ONE_Q28 = XY_W'(1) <<< 28;
    localparam logic signed [Z_W-1:0]  PI_Q24  = Z_W'(52707179);
    localparam logic signed [Z_W-1:0]  ROUND_Q24_TO_Q13 = Z_W'(1024);
    localparam int unsigned            Q13_SHIFT = 11;
    localparam int unsigned            Q_W = Z_W - Q13_SHIFT;
    localparam logic signed [Q_W-1:0]  YAW_LIMIT = Q_W'(25736);

    localparam logic signed [Z_W-1:0] ATAN_LO [8] = '{
        Z_W'(13176795), Z_W'(7778716), Z_W'(4110060), Z_W'(2086331),
        Z_W'(1047214),  Z_W'(524117),  Z_W'(262123),  Z_W'(131069)
    };

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_vec_t;

    // atan(2^-i) in Q24, rounded; exact power of two from step 8 on
    function automatic logic signed [Z_W-1:0] atan_q24(input int unsigned i);
        logic signed [Z_W-1:0] r;
        if (i < 8)
        begin
            r = ATAN_LO[i[2:0]];
        end
        else
        begin
            r = Z_W'(1) <<< (MAX_STEPS - i);
        end
        return r;
    endfunction

endpackage

@@ src/quaternion_yaw_hold_core.sv @@
// Quaternion yaw hold.
// Input channel (in_valid / in_stall) carries one sensor poll per transaction:
// event_valid, the four Q14 quaternion parts and a Q13 fallback heading.
// Output channel (out_valid / out_stall) returns exactly one heading per
// poll, in order: the fallback until the first valid quaternion, the held
// yaw (Q13 radians, saturated to +/-pi) from then on; from_quaternion says
// which.
// One poll is in flight at a time. A poll walks two set-up stages
// (products, then vector fold), the chain of N CORDIC cells,
// N = min(CORDIC_STEPS, 24) with a default of 16, one stage that rounds,
// saturates and updates the held yaw, and the output register, where
// out_valid rises; only then can the next poll be accepted.
// A result waiting under out_stall does not hold up the next poll: it is
// accepted and computed, and only its hand-over to the output register
// waits until that register is free.
// Reset (rst_n, asynchronous) empties the block, clears the held yaw and
// marks that no quaternion has been seen yet.
module quaternion_yaw_hold_core #(
    parameter int unsigned CORDIC_STEPS = qyh_pkg::CORDIC_STEPS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                event_valid,
    input  logic signed [qyh_pkg::QUAT_W-1:0]   quat_i,
    input  logic signed [qyh_pkg::QUAT_W-1:0]   quat_j,
    input  logic signed [qyh_pkg::QUAT_W-1:0]   quat_k,
    input  logic signed [qyh_pkg::QUAT_W-1:0]   quat_real,
    input  logic signed [qyh_pkg::HEAD_W-1:0]   fallback_heading,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [qyh_pkg::HEAD_W-1:0]   heading,
    output logic                                from_quaternion
);
    import qyh_pkg::*;

    localparam int unsigned N = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;

    // transaction control
    logic                       accept;
    logic                       busy_reg, busy_next;
    logic                       pending_reg, pending_next;
    logic                       ev_reg;
    logic signed [HEAD_W-1:0]   fallback_reg;
    logic                       zero_reg;

    // held state
    logic signed [YAW_W-1:0]    held_yaw_reg, held_yaw_next;
    logic                       awaiting_reg, awaiting_next;

    // output register
    logic                       out_valid_reg, out_valid_next;
    logic signed [HEAD_W-1:0]   heading_reg;
    logic                       from_q_reg;
    logic                       out_load;

    // set-up stages feed cell 0
    cordic_vec_t                chain_vec [N+1];
    logic                       chain_vld [N+1];
    logic                       prep_zero;

    logic signed [Z_W-1:0]      z_rnd;
    logic signed [Q_W-1:0]      q;
    logic signed [YAW_W-1:0]    yaw_sat;
    logic                       finish;

    assign accept   = in_valid && !busy_reg;
    assign in_stall = busy_reg;

    qyh_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .quat_i    (quat_i),
        .quat_j    (quat_j),
        .quat_k    (quat_k),
        .quat_real (quat_real),
        .vec_reg   (chain_vec[0]),
        .vld_reg   (chain_vld[0]),
        .zero_reg  (prep_zero)
    );

    // chain of rotation cells, cell i shifts by i
    for (genvar g = 0; g < N; g++)
    begin : g_cell
        qyh_cell #(
            .SHIFT (g)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .in_vec      (chain_vec[g]),
            .in_vld      (chain_vld[g]),
            .out_vec_reg (chain_vec[g+1]),
            .out_vld_reg (chain_vld[g+1])
        );
    end

    // per-transaction payload, captured once
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ev_reg       <= event_valid;
            fallback_reg <= fallback_heading;
        end
        if (chain_vld[0])
        begin
            zero_reg <= prep_zero;
        end
    end

    // Q24 -> Q13 with rounding, then clamp to +/-pi
    assign finish = chain_vld[N];

    always_comb
    begin
        z_rnd = chain_vec[N].z + ROUND_Q24_TO_Q13;
        q     = $signed(z_rnd[Z_W-1:Q13_SHIFT]);
        if (q > YAW_LIMIT)
        begin
            yaw_sat = YAW_LIMIT[YAW_W-1:0];
        end
        else if (q < -YAW_LIMIT)
        begin
            yaw_sat = -YAW_LIMIT[YAW_W-1:0];
        end
        else
        begin
            yaw_sat = q[YAW_W-1:0];
        end
    end

    // held state only moves on a poll that carried a quaternion
    always_comb
    begin
        held_yaw_next = held_yaw_reg;
        awaiting_next = awaiting_reg;
        if (finish && ev_reg)
        begin
            held_yaw_next = zero_reg ? '0 : yaw_sat;
            awaiting_next = 1'b0;
        end
    end

    assign out_load = pending_reg && (!out_valid_reg || !out_stall);

    always_comb
    begin
        busy_next      = busy_reg;
        pending_next   = pending_reg;
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        if (finish)
        begin
            pending_next = 1'b1;
        end
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            pending_next   = 1'b0;
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            held_yaw_reg  <= '0;
            awaiting_reg  <= 1'b1;
        end
        else
        begin
            busy_reg      <= busy_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
            held_yaw_reg  <= held_yaw_next;
            awaiting_reg  <= awaiting_next;
        end
    end

    // result is read from the state after this poll's update
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            heading_reg <= awaiting_reg ? fallback_reg : HEAD_W'(held_yaw_reg);
            from_q_reg  <= !awaiting_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign heading         = heading_reg;
    assign from_quaternion = from_q_reg;

endmodule

@@ src/qyh_prep.sv @@
module qyh_prep (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [15:0]          quat_i,
    input  logic signed [15:0]          quat_j,
    input  logic signed [15:0]          quat_k,
    input  logic signed [15:0]          quat_real,
    output qyh_pkg::cordic_vec_t        vec_reg,
    output logic                        vld_reg,
    output logic                        zero_reg
);
    import qyh_pkg::*;

    logic signed [PROD_W-1:0] p_rk_reg, p_ij_reg, p_jj_reg, p_kk_reg;
    logic                     vld1_reg;

    logic signed [XY_W-1:0]   y_raw, x_raw;
    cordic_vec_t              vec_next;
    logic                     zero_next;

    // stage 1: the four products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            p_rk_reg <= quat_real * quat_k;
            p_ij_reg <= quat_i * quat_j;
            p_jj_reg <= quat_j * quat_j;
            p_kk_reg <= quat_k * quat_k;
        end
    end

    // stage 2: Q28 vector, folded into the right half-plane
    always_comb
    begin
        y_raw = (XY_W'(p_rk_reg) + XY_W'(p_ij_reg)) <<< 1;
        x_raw = ONE_Q28 - ((XY_W'(p_jj_reg) + XY_W'(p_kk_reg)) <<< 1);
        zero_next = (x_raw == '0) && (y_raw == '0);
        if (x_raw[XY_W-1])
        begin
            vec_next.x = -x_raw;
            vec_next.y = -y_raw;
            vec_next.z = y_raw[XY_W-1] ? -PI_Q24 : PI_Q24;
        end
        else
        begin
            vec_next.x = x_raw;
            vec_next.y = y_raw;
            vec_next.z = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vld1_reg)
        begin
            vec_reg  <= vec_next;
            zero_reg <= zero_next;
        end
    end

endmodule

@@ src/qyh_cell.sv @@
module qyh_cell #(
    parameter int unsigned SHIFT = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  qyh_pkg::cordic_vec_t        in_vec,
    input  logic                        in_vld,
    output qyh_pkg::cordic_vec_t        out_vec_reg,
    output logic                        out_vld_reg
);
    import qyh_pkg::*;

    localparam logic signed [Z_W-1:0] ANGLE = atan_q24(SHIFT);

    logic signed [XY_W-1:0] dx, dy;
    cordic_vec_t            vec_next;

    // one vectoring rotation, both updates from the old x and y
    always_comb
    begin
        dx = in_vec.y >>> SHIFT;
        dy = in_vec.x >>> SHIFT;
        if (!in_vec.y[XY_W-1])
        begin
            vec_next.x = in_vec.x + dx;
            vec_next.y = in_vec.y - dy;
            vec_next.z = in_vec.z + ANGLE;
        end
        else
        begin
            vec_next.x = in_vec.x - dx;
            vec_next.y = in_vec.y + dy;
            vec_next.z = in_vec.z - ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        out_vec_reg <= vec_next;
    end

endmodule

@@ src/qyh_checker.sv @@
`include "quaternion_yaw_hold_core_macros.svh"

module qyh_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic signed [qyh_pkg::HEAD_W-1:0]    heading,
    input logic                                 from_quaternion
);

    // a held result stays put
    `QYH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `QYH_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
        $stable(heading) && $stable(from_quaternion))
    // one poll in flight: input closes right after a transaction
    `QYH_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    // once a quaternion has been seen, fallback never returns
    `QYH_ASSERT_NEXT(a_yaw_sticky, out_valid && from_quaternion,
        !out_valid || from_quaternion)

endmodule

bind quaternion_yaw_hold_core qyh_checker u_qyh_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .heading         (heading),
    .from_quaternion (from_quaternion)
);

@@ tb/tb_quaternion_yaw_hold_core.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the quaternion yaw hold core.
// Polls go in one transaction at a time over in_valid / in_stall; every
// accepted poll is run through a local copy of the yaw arithmetic and the
// heading it should produce is queued. Each transaction on the result
// channel is popped against that queue, field by field.
module tb_quaternion_yaw_hold_core;

    import qyh_pkg::*;

    // Steps the core actually walks (capped at the package maximum)
    localparam int unsigned CORDIC_N =
        (CORDIC_STEPS_DEFAULT > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS_DEFAULT;
    // Acceptance-to-acceptance spacing of the core
    localparam int unsigned POLL_CYCLES = CORDIC_N + 4;

    localparam longint PI_Q24_VAL   = 64'sd52707179;
    localparam longint YAW_SAT_Q13  = 64'sd25736;
    // atan(2^-s) in Q24 for the first eight steps; powers of two after that
    localparam longint ATAN_Q24 [8] = '{
        64'sd13176795, 64'sd7778716, 64'sd4110060, 64'sd2086331,
        64'sd1047214,  64'sd524117,  64'sd262123,  64'sd131069
    };

    typedef struct {
        logic signed [HEAD_W-1:0] heading;
        logic                     from_quaternion;
    } heading_result_t;

    logic                      clk;
    logic                      rst_n            = 1'b0;
    logic                      in_valid         = 1'b0;
    logic                      in_stall;
    logic                      event_valid      = 1'b0;
    logic signed [QUAT_W-1:0]  quat_i           = '0;
    logic signed [QUAT_W-1:0]  quat_j           = '0;
    logic signed [QUAT_W-1:0]  quat_k           = '0;
    logic signed [QUAT_W-1:0]  quat_real        = '0;
    logic signed [HEAD_W-1:0]  fallback_heading = '0;
    logic                      out_valid;
    logic                      out_stall        = 1'b0;
    logic signed [HEAD_W-1:0]  heading;
    logic                      from_quaternion;

    // Local view of the core's state
    logic signed [YAW_W-1:0]   yaw_held         = '0;
    logic                      no_quat_yet      = 1'b1;

    heading_result_t           heading_expect_q [$];
    int                        mismatch_count   = 0;
    bit                        poll_gaps_on     = 1'b0;
    bit                        result_stall_on  = 1'b0;

    quaternion_yaw_hold_core #(
        .CORDIC_STEPS(CORDIC_N)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .event_valid(event_valid),
        .quat_i(quat_i),
        .quat_j(quat_j),
        .quat_k(quat_k),
        .quat_real(quat_real),
        .fallback_heading(fallback_heading),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .heading(heading),
        .from_quaternion(from_quaternion)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Generous ceiling on the whole run; reaching it fails the run
    initial
    begin
        #1_000_000;
        $display("tb_quaternion_yaw_hold_core failed");
        $finish;
    end

    // yaw = atan2(2(rk + ij), 1 - 2(j^2 + k^2)) in Q13 radians.
    // Vectors are exact Q28 integers; the CORDIC runs in vectoring mode with
    // a Q24 angle, left half-plane folded over first by +/-pi. Arithmetic
    // right shifts on longint give the floor the core uses.
    function automatic logic signed [YAW_W-1:0] quat_yaw_q13(
        input logic signed [QUAT_W-1:0] qi,
        input logic signed [QUAT_W-1:0] qj,
        input logic signed [QUAT_W-1:0] qk,
        input logic signed [QUAT_W-1:0] qr
    );
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint step_angle;
        longint q;
        y = 2 * (longint'(qr) * longint'(qk) + longint'(qi) * longint'(qj));
        x = (longint'(1) <<< 28)
            - 2 * (longint'(qj) * longint'(qj) + longint'(qk) * longint'(qk));
        if (x == 0 && y == 0)
        begin
            return '0;
        end
        z = 0;
        if (x < 0)
        begin
            // y = 0 counts as upper half-plane, hence +pi
            z = (y >= 0) ? PI_Q24_VAL : -PI_Q24_VAL;
            x = -x;
            y = -y;
        end
        for (int s = 0; s < int'(CORDIC_N); s++)
        begin
            dx = y >>> s;
            dy = x >>> s;
            step_angle = (s < 8) ? ATAN_Q24[s[2:0]] : (longint'(1) <<< (24 - s));
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + step_angle;
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - step_angle;
            end
        end
        // Q24 -> Q13, round half up, then clamp to +/-pi
        q = (z + 1024) >>> 11;
        if (q > YAW_SAT_Q13)
        begin
            q = YAW_SAT_Q13;
        end
        if (q < -YAW_SAT_Q13)
        begin
            q = -YAW_SAT_Q13;
        end
        return YAW_W'(q);
    endfunction

    // Offer one poll, hold it until the core takes it, then update the local
    // state and queue the heading that this transaction must return.
    // in_valid is left high on return; the next call or the end of the run
    // decides whether it drops.
    task automatic send_poll(
        input logic                     ev,
        input logic signed [QUAT_W-1:0] qi,
        input logic signed [QUAT_W-1:0] qj,
        input logic signed [QUAT_W-1:0] qk,
        input logic signed [QUAT_W-1:0] qr,
        input logic signed [HEAD_W-1:0] fb
    );
        heading_result_t r;
        int              gap;
        if (poll_gaps_on && $urandom_range(0, 3) == 0)
        begin
            // idle burst of random length, counted from when the core is ready
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            @(posedge clk);
            while (in_stall)
            begin
                @(posedge clk);
            end
            repeat (gap - 1) @(posedge clk);
        end
        in_valid         <= 1'b1;
        event_valid      <= ev;
        quat_i           <= qi;
        quat_j           <= qj;
        quat_k           <= qk;
        quat_real        <= qr;
        fallback_heading <= fb;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        if (ev)
        begin
            yaw_held    = quat_yaw_q13(qi, qj, qk, qr);
            no_quat_yet = 1'b0;
        end
        if (no_quat_yet)
        begin
            r.heading         = fb;
            r.from_quaternion = 1'b0;
        end
        else
        begin
            r.heading         = HEAD_W'(yaw_held);
            r.from_quaternion = 1'b1;
        end
        heading_expect_q.push_back(r);
    endtask

    function automatic logic signed [QUAT_W-1:0] rand_q14();
        return QUAT_W'(int'($urandom_range(0, 32768)) - 16384);
    endfunction

    // Empty polls before any quaternion: fallback must come back untouched,
    // including values outside the nominal range and all-ones bit patterns.
    // Junk in the quaternion fields must be ignored.
    task automatic test_fallback_passthrough();
        send_poll(1'b0, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, -17'sd25736);
        send_poll(1'b0, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 17'sd51472);
        send_poll(1'b0, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 17'sd0);
        send_poll(1'b0, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 17'sh10000);
        send_poll(1'b0, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 17'sh0FFFF);
        send_poll(1'b0, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 17'sh1FFFF);
    endtask

    // Corner vectors of the atan2 and the hold behaviour afterwards
    task automatic test_special_vectors();
        // identity: yaw 0
        send_poll(1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 17'sd100);
        // x = y = 0 exactly: yaw forced to 0
        send_poll(1'b1, 16'sd0, 16'sd8192, 16'sd8192, 16'sd0, 17'sd0);
        send_poll(1'b1, 16'sd5, 16'sd8192, 16'sd8192, -16'sd5, 17'sd0);
        // left half-plane on the axis: +pi, then either side of it
        send_poll(1'b1, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 17'sd0);
        send_poll(1'b1, -16'sd1, 16'sd16384, 16'sd0, 16'sd0, 17'sd0);
        send_poll(1'b1, 16'sd1, 16'sd16384, 16'sd0, 16'sd0, 17'sd0);
        // near +/- pi/2
        send_poll(1'b1, 16'sd0, 16'sd0, 16'sd11585, 16'sd11585, 17'sd0);
        send_poll(1'b1, 16'sd0, 16'sd0, -16'sd11585, 16'sd11585, 17'sd0);
        // field extremes, in range and beyond
        send_poll(1'b1, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 17'sd0);
        send_poll(1'b1, -16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384, 17'sd0);
        send_poll(1'b1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 17'sd0);
        send_poll(1'b1, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 17'sd0);
        send_poll(1'b1, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 17'sd0);
        // empty polls now return the held yaw, not the fallback
        send_poll(1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 17'sd51472);
        send_poll(1'b0, 16'sh7FFF, 16'sh8000, 16'sd0, 16'sd0, -17'sd25736);
    endtask

    // One random poll: mostly normalised quaternions (some with a dominant
    // yaw rotation so the heading sweeps through +/-pi), plus raw in-range
    // parts, full-width noise and empty polls.
    task automatic random_poll();
        int                       kind;
        real                      c [4];
        real                      nrm;
        logic signed [QUAT_W-1:0] q [4];
        kind = $urandom_range(0, 99);
        if (kind < 20)
        begin
            send_poll(1'b0, QUAT_W'($urandom), QUAT_W'($urandom), QUAT_W'($urandom),
                      QUAT_W'($urandom), HEAD_W'($urandom));
        end
        else if (kind < 30)
        begin
            send_poll(1'b1, QUAT_W'($urandom), QUAT_W'($urandom), QUAT_W'($urandom),
                      QUAT_W'($urandom), HEAD_W'($urandom));
        end
        else if (kind < 45)
        begin
            send_poll(1'b1, rand_q14(), rand_q14(), rand_q14(), rand_q14(),
                      HEAD_W'($urandom));
        end
        else
        begin
            for (int n = 0; n < 4; n++)
            begin
                c[n] = real'(int'($urandom_range(0, 65534)) - 32767);
            end
            if (kind < 65)
            begin
                // small tilt: i and j tiny next to k and real
                c[0] = c[0] / 64.0;
                c[1] = c[1] / 64.0;
            end
            nrm = $sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2] + c[3] * c[3]);
            if (nrm < 1.0)
            begin
                c[3] = 1.0;
                nrm  = 1.0;
            end
            for (int n = 0; n < 4; n++)
            begin
                q[n] = QUAT_W'($rtoi(c[n] * 16384.0 / nrm));
            end
            send_poll(1'b1, q[0], q[1], q[2], q[3], HEAD_W'($urandom));
        end
    endtask

    // Bulk random traffic with gaps on the poll side and stalls on the
    // result side
    task automatic test_random_orientations();
        poll_gaps_on    = 1'b1;
        result_stall_on = 1'b1;
        repeat (960) random_poll();
    endtask

    // Closing stretch at full rate: no gaps, no stalls
    task automatic test_back_to_back_polls();
        poll_gaps_on    = 1'b0;
        result_stall_on = 1'b0;
        repeat (120) random_poll();
    endtask

    // Result-side back-pressure: stall bursts of random length, with the odd
    // quiet stretch so long runs without stalls also occur
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (result_stall_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (result_stall_on && $urandom_range(0, 63) == 0)
            begin
                repeat ($urandom_range(30, 80)) @(posedge clk);
            end
        end
    end

    // Result checker: one pop per accepted transaction, oldest first
    always @(posedge clk)
    begin : heading_check
        heading_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (heading_expect_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("%0t: unexpected result heading=%0d from_quaternion=%0b",
                             $realtime, heading, from_quaternion);
                end
            end
            else
            begin
                exp_r = heading_expect_q.pop_front();
                if (heading !== exp_r.heading
                    || from_quaternion !== exp_r.from_quaternion)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("%0t: mismatch heading exp %0d got %0d, from_q exp %0b got %0b",
                                 $realtime, exp_r.heading, heading,
                                 exp_r.from_quaternion, from_quaternion);
                    end
                end
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fallback_passthrough();
        test_special_vectors();
        test_random_orientations();
        test_back_to_back_polls();

        in_valid <= 1'b0;
        // drain; a lost result is caught by the watchdog
        while (heading_expect_q.size() != 0)
        begin
            @(posedge clk);
        end
        // let any stray extra transaction show itself
        repeat (4 * POLL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && heading_expect_q.size() == 0)
        begin
            $display("tb_quaternion_yaw_hold_core passed");
        end
        else
        begin
            $display("tb_quaternion_yaw_hold_core failed");
        end
        $finish;
    end

endmodule
